// ===== hw/rtl/wildcard_tuple_filter_table_macros.svh =====
// Assertion macros used by the filter table top level.
`ifndef WILDCARD_TUPLE_FILTER_TABLE_MACROS_SVH
`define WILDCARD_TUPLE_FILTER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WTFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wtft: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define WTFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wtft: property violated");

`endif

// ===== hw/rtl/wtft_pkg.sv =====
// Shared constants and types of the wildcard tuple filter table.
package wtft_pkg;

  localparam int MAX_RULES = 16;
  // Wide enough to hold MAX_RULES itself.
  localparam int CNT_W = $clog2(MAX_RULES + 1);

  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;

  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_PASS    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FLUSHED = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
  } tuple_t;

  // Item travelling down the cell chain.
  typedef struct packed {
    logic                vld;
    logic                check;
    logic [STATUS_W-1:0] status;
    tuple_t              key;
  } token_t;

endpackage

// ===== hw/rtl/wtft_cell.sv =====
// One rule cell: stores a rule and matches the passing token against it.
module wtft_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wtft_pkg::token_t tok_i,
  output logic            rdy_o,
  output wtft_pkg::token_t tok_o,
  input  logic            rdy_i,
  input  logic            rule_live_i,
  input  logic            wr_en_i,
  input  wtft_pkg::tuple_t wr_rule_i
);

  wtft_pkg::tuple_t rule_q;
  wtft_pkg::token_t tok_q, tok_d;
  logic             hit;
  logic             take;

  // Zero in a rule field is a wildcard.
  assign hit = ((rule_q.src_addr == '0) || (rule_q.src_addr == tok_i.key.src_addr)) &&
               ((rule_q.dst_addr == '0) || (rule_q.dst_addr == tok_i.key.dst_addr)) &&
               ((rule_q.src_port == '0) || (rule_q.src_port == tok_i.key.src_port)) &&
               ((rule_q.dst_port == '0) || (rule_q.dst_port == tok_i.key.dst_port));

  always_comb begin
    tok_d = tok_i;
    if (tok_i.check && rule_live_i && hit) begin
      tok_d.status = wtft_pkg::ST_REJECT;
    end
  end

  // Bubbles collapse: an empty stage always takes.
  assign take  = !tok_q.vld || rdy_i;
  assign rdy_o = take;
  assign tok_o = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (take) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rule_q <= wr_rule_i;
    end
  end

endmodule

// ===== hw/rtl/wildcard_tuple_filter_table.sv =====
// Top level of the wildcard four-tuple packet filter table.
//
// Input channel (in_valid_i / in_stall_o) carries mode_i and a tuple; output
// channel (out_valid_o / out_stall_i) returns one status_o per input item, in
// order. mode 0 checks a packet tuple against all stored rules, mode 1
// appends a rule, mode 2 empties the table, mode 3 answers pass.
// Rules sit one per cell in a chain of MAX_RULES cells. Every item walks the
// chain one cell per cycle while the cell ahead can take it, and its result
// is shown from the last cell. Checks and mode 3 items follow each
// other back to back, one per cycle, unless the output stalls. An append or
// flush is taken only when the chain is empty, so older items drain first.
// Appends and flushes update the table in the cycle of their transfer.
// When the receiver stalls, the last cell holds its result and earlier items
// close up behind it; input is stalled once the first cell cannot move.
// Reset empties the chain and the rule count; rule contents are not cleared
// and need no clearing pass, since only written entries are ever examined.
`include "wildcard_tuple_filter_table_macros.svh"

module wildcard_tuple_filter_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wtft_pkg::MODE_W-1:0]   mode_i,
  input  logic [wtft_pkg::ADDR_W-1:0]   src_addr_i,
  input  logic [wtft_pkg::ADDR_W-1:0]   dst_addr_i,
  input  logic [wtft_pkg::PORT_W-1:0]   src_port_i,
  input  logic [wtft_pkg::PORT_W-1:0]   dst_port_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wtft_pkg::STATUS_W-1:0] status_o
);

  localparam int N  = wtft_pkg::MAX_RULES;
  localparam int CW = wtft_pkg::CNT_W;

  wtft_pkg::token_t tok   [N+1];
  logic             rdy   [N+1];
  wtft_pkg::tuple_t in_rule;
  wtft_pkg::token_t in_tok;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] inflight_q, inflight_d;
  logic          in_acc, out_acc;
  logic          drain_mode;
  logic          is_append, is_flush;
  logic          full;
  logic          append_acc;

  assign in_rule.src_addr = src_addr_i;
  assign in_rule.dst_addr = dst_addr_i;
  assign in_rule.src_port = src_port_i;
  assign in_rule.dst_port = dst_port_i;

  assign is_append  = (mode_i == wtft_pkg::MODE_APPEND);
  assign is_flush   = (mode_i == wtft_pkg::MODE_FLUSH);
  assign drain_mode = is_append || is_flush;
  assign full       = (count_q == CW'(N));

  // Table writes wait until no older item is still walking the chain.
  assign in_stall_o = !rdy[0] || (drain_mode && (inflight_q != '0));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = tok[N].vld && !out_stall_i;
  assign append_acc = in_acc && is_append && !full;

  always_comb begin
    in_tok.vld   = in_acc;
    in_tok.check = (mode_i == wtft_pkg::MODE_CHECK);
    in_tok.key   = in_rule;
    if (is_append) begin
      in_tok.status = full ? wtft_pkg::ST_FULL : wtft_pkg::ST_STORED;
    end else if (is_flush) begin
      in_tok.status = wtft_pkg::ST_FLUSHED;
    end else begin
      in_tok.status = wtft_pkg::ST_PASS;
    end
  end

  assign tok[0] = in_tok;
  assign rdy[N] = !out_stall_i;

  for (genvar k = 0; k < N; k++) begin : g_cell
    wtft_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok[k]),
      .rdy_o       (rdy[k]),
      .tok_o       (tok[k+1]),
      .rdy_i       (rdy[k+1]),
      .rule_live_i (CW'(k) < count_q),
      .wr_en_i     (append_acc && (count_q == CW'(k))),
      .wr_rule_i   (in_rule)
    );
  end

  always_comb begin
    count_d = count_q;
    if (append_acc) begin
      count_d = count_q + CW'(1);
    end else if (in_acc && is_flush) begin
      count_d = '0;
    end
  end

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + CW'(1);
    end else if (!in_acc && out_acc) begin
      inflight_d = inflight_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      inflight_q <= '0;
    end else begin
      count_q    <= count_d;
      inflight_q <= inflight_d;
    end
  end

  assign out_valid_o = tok[N].vld;
  assign status_o    = tok[N].status;

  `WTFT_ASSERT_IMP(a_out_has_item, clk_i, rst_ni, out_valid_o, inflight_q != '0)
  `WTFT_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(N))
  `WTFT_ASSERT_IMP(a_write_drained, clk_i, rst_ni, in_acc && drain_mode,
                   inflight_q == '0)
  `WTFT_ASSERT_NXT(a_append_grows, clk_i, rst_ni, append_acc,
                   count_q == $past(count_q) + CW'(1))
  `WTFT_ASSERT_IMP(a_inflight_bound, clk_i, rst_ni, 1'b1, inflight_q <= CW'(N))

endmodule
